// ===== src/chunked_message_reassembler_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the chunked message reassembler
// Shared wrappers around concurrent assertions, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_MESSAGE_REASSEMBLER_ASSERT_SVH
`define CHUNKED_MESSAGE_REASSEMBLER_ASSERT_SVH

// same-cycle implication
`define CMR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cmr_pkg.sv =====
// ----------------------------------------------------------------------------
// cmr_pkg
// Types and constants of the chunked message reassembler.
// ----------------------------------------------------------------------------
package cmr_pkg;

  localparam int BUFFER_BYTES   = 512;
  localparam int CHUNK_TEXT_MAX = 64;
  localparam int ADDR_W         = $clog2(BUFFER_BYTES);

  typedef enum logic [1:0] {
    ACT_HEADER = 2'd0,
    ACT_BYTE   = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_STORED   = 3'd1,
    ST_COMPLETE = 3'd2,
    ST_BAD      = 3'd3,
    ST_SEQ      = 3'd4,
    ST_IGNORED  = 3'd5,
    ST_READ     = 3'd6
  } status_t;

endpackage

// ===== src/cmr_in_if.sv =====
// ----------------------------------------------------------------------------
// cmr_in_if
// Request channel: valid/ready handshake with one header, byte or read item.
// ----------------------------------------------------------------------------
interface cmr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] message_id;
  logic [7:0] chunk_number;
  logic [7:0] chunk_total;
  logic [7:0] text_length;
  logic [7:0] text_byte;
  logic [8:0] read_position;

  modport source (output valid, action, message_id, chunk_number, chunk_total,
                  text_length, text_byte, read_position, input ready);
  modport sink   (input valid, action, message_id, chunk_number, chunk_total,
                  text_length, text_byte, read_position, output ready);
endinterface

// ===== src/cmr_out_if.sv =====
// ----------------------------------------------------------------------------
// cmr_out_if
// Response channel: valid/ready handshake with one status result.
// ----------------------------------------------------------------------------
interface cmr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [8:0] message_length;
  logic [7:0] read_data;

  modport source (output valid, status, message_length, read_data, input ready);
  modport sink   (input valid, status, message_length, read_data, output ready);
endinterface

// ===== src/chunked_message_reassembler.sv =====
// ----------------------------------------------------------------------------
// chunked_message_reassembler
// Rebuilds a message from numbered chunks into a 512-byte store.
// ----------------------------------------------------------------------------
// req carries one item per transfer: a chunk header, one text byte, or a read
// of a stored byte. rsp returns exactly one status result per request, in
// order. Headers are checked for shape and sequence; text bytes are appended
// to the store; the last byte of the last chunk, or an empty last chunk's header,
// reports completion with the total length. Reads return the byte at read_position.
// Each result is registered and shows on rsp in the cycle after its request.
// Throughput is one item per cycle while rsp is not stalled; the store is a
// single-port-write, registered-read RAM, written by byte items and read by
// read items, one access per item, so no two accesses ever meet in a cycle.
// rsp is a single output register: while it holds an untaken result and the
// receiver stalls, req.ready drops; it returns as the result is taken.
// Reset (rst, synchronous) clears the session and drops rsp.valid. The store
// is not cleared; it only holds what byte items wrote.
// ----------------------------------------------------------------------------
module chunked_message_reassembler
  import cmr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  cmr_in_if.sink       req,
  cmr_out_if.source    rsp
);

  localparam int FILL_W = ADDR_W;
  localparam logic [FILL_W:0] BUF_LIMIT = (FILL_W+1)'(BUFFER_BYTES);
  localparam logic [7:0]      TEXT_MAX  = 8'(CHUNK_TEXT_MAX);

  // session state
  logic [7:0]        current_message, current_message_next;
  logic [7:0]        next_chunk, next_chunk_next;
  logic [7:0]        expected_total, expected_total_next;
  logic [FILL_W-1:0] fill_level, fill_level_next;
  logic [7:0]        bytes_owed, bytes_owed_next;

  // output register
  logic              out_valid;
  status_t           out_status;
  logic [8:0]        out_length;
  logic              out_is_read;

  logic [7:0]        mem [BUFFER_BYTES];
  logic [7:0]        rd_q;

  logic              accept;
  action_t           act;
  status_t           res_status;
  logic [8:0]        res_length;
  logic              res_is_read;
  logic              wr_en;
  logic              rd_en;
  logic              rd_in_range;

  // header view after an index-zero restart
  logic [7:0]        hdr_cur;
  logic [7:0]        hdr_nc;
  logic [7:0]        hdr_exp;
  logic [FILL_W-1:0] hdr_fill;
  logic [FILL_W:0]   hdr_sum;
  logic [7:0]        hdr_nc_inc;
  logic [7:0]        byte_nc_inc;
  logic [FILL_W-1:0] fill_inc;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign act       = action_t'(req.action);

  assign hdr_cur     = (req.chunk_number == 8'd0) ? req.message_id  : current_message;
  assign hdr_nc      = (req.chunk_number == 8'd0) ? 8'd0            : next_chunk;
  assign hdr_exp     = (req.chunk_number == 8'd0) ? req.chunk_total : expected_total;
  assign hdr_fill    = (req.chunk_number == 8'd0) ? '0              : fill_level;
  assign hdr_sum     = {1'b0, hdr_fill} + (FILL_W+1)'(req.text_length);
  assign hdr_nc_inc  = hdr_nc + 8'd1;
  assign byte_nc_inc = next_chunk + 8'd1;
  assign fill_inc    = fill_level + FILL_W'(1);

  assign rd_in_range = ({1'b0, req.read_position} < 10'(BUFFER_BYTES));
  assign rd_en       = accept && (act == ACT_READ);

  always_comb begin
    current_message_next = current_message;
    next_chunk_next      = next_chunk;
    expected_total_next  = expected_total;
    fill_level_next      = fill_level;
    bytes_owed_next      = bytes_owed;
    res_status           = ST_IGNORED;
    res_length           = '0;
    res_is_read          = 1'b0;
    wr_en                = 1'b0;
    if (accept) begin
      unique case (act)
        ACT_HEADER: begin
          if (bytes_owed != 8'd0) begin
            res_status = ST_SEQ;
          end else if (req.chunk_total == 8'd0 || req.chunk_number >= req.chunk_total ||
                       req.text_length > TEXT_MAX) begin
            res_status = ST_BAD;
          end else if (req.message_id != hdr_cur || req.chunk_total != hdr_exp ||
                       req.chunk_number != hdr_nc || hdr_sum >= BUF_LIMIT) begin
            res_status = ST_SEQ;
          end else if (req.text_length == 8'd0) begin
            // empty chunk finishes at once
            if (hdr_nc_inc == hdr_exp) begin
              res_status = ST_COMPLETE;
              res_length = 9'(hdr_fill);
            end else begin
              res_status           = ST_ACCEPTED;
              current_message_next = hdr_cur;
              next_chunk_next      = hdr_nc_inc;
              expected_total_next  = hdr_exp;
              fill_level_next      = hdr_fill;
            end
          end else begin
            res_status           = ST_ACCEPTED;
            current_message_next = hdr_cur;
            next_chunk_next      = hdr_nc;
            expected_total_next  = hdr_exp;
            fill_level_next      = hdr_fill;
            bytes_owed_next      = req.text_length;
          end
          // every outcome but a plain accept closes the session
          if (res_status != ST_ACCEPTED) begin
            current_message_next = '0;
            next_chunk_next      = '0;
            expected_total_next  = '0;
            fill_level_next      = '0;
            bytes_owed_next      = '0;
          end
        end
        ACT_BYTE: begin
          if (bytes_owed != 8'd0) begin
            wr_en           = 1'b1;
            fill_level_next = fill_inc;
            bytes_owed_next = bytes_owed - 8'd1;
            res_status      = ST_STORED;
            if (bytes_owed == 8'd1) begin
              if (byte_nc_inc == expected_total) begin
                res_status           = ST_COMPLETE;
                res_length           = 9'(fill_inc);
                current_message_next = '0;
                next_chunk_next      = '0;
                expected_total_next  = '0;
                fill_level_next      = '0;
              end else begin
                next_chunk_next = byte_nc_inc;
              end
            end
          end
        end
        ACT_READ: begin
          res_status  = ST_READ;
          res_is_read = rd_in_range;
        end
        ACT_NONE: begin
          res_status = ST_IGNORED;
        end
        default: begin
          res_status = ST_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_message <= '0;
      next_chunk      <= '0;
      expected_total  <= '0;
      fill_level      <= '0;
      bytes_owed      <= '0;
      out_valid       <= 1'b0;
    end else begin
      current_message <= current_message_next;
      next_chunk      <= next_chunk_next;
      expected_total  <= expected_total_next;
      fill_level      <= fill_level_next;
      bytes_owed      <= bytes_owed_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status  <= res_status;
      out_length  <= res_length;
      out_is_read <= res_is_read;
    end
  end

  // message store: one write or one read per item, registered read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_level] <= req.text_byte;
    end
    if (rd_en) begin
      rd_q <= mem[req.read_position[ADDR_W-1:0]];
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.message_length = out_length;
  assign rsp.read_data      = out_is_read ? rd_q : 8'd0;

endmodule

// ===== src/cmr_checker.sv =====
// ----------------------------------------------------------------------------
// cmr_checker
// Port-level checks of the chunked message reassembler, bound to the top.
// ----------------------------------------------------------------------------
`include "chunked_message_reassembler_assert.svh"

module cmr_checker
  import cmr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] rsp_status,
  input logic [8:0] rsp_message_length,
  input logic [7:0] rsp_read_data
);

  // a stalled result must hold
  `CMR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
    rsp_valid && $stable(rsp_status) && $stable(rsp_message_length) &&
    $stable(rsp_read_data), "rsp changed while stalled")

  // every request transfer yields a result in the next cycle
  `CMR_ASSERT_NEXT(a_one_cycle, req_valid && req_ready, rsp_valid,
    "no result after request transfer")

  `CMR_ASSERT_NOW(a_len_only_complete, rsp_valid && rsp_status != ST_COMPLETE,
    rsp_message_length == 9'd0, "length set without completion")

  `CMR_ASSERT_NOW(a_data_only_read, rsp_valid && rsp_status != ST_READ,
    rsp_read_data == 8'd0, "read data set on non-read result")

endmodule

bind chunked_message_reassembler cmr_checker u_cmr_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_message_length (rsp.message_length),
  .rsp_read_data      (rsp.read_data)
);
